// File: rtl/core/rtv_pkg.sv
// ----------------------------------------------------------------------------
// rtv_pkg
// Shared constants, codes and widths for the vector-to-vector rotation block.
// ----------------------------------------------------------------------------
package rtv_pkg;

  // output fraction bits and internal unit-vector fraction bits
  localparam int FRAC_BITS = 14;
  localparam int IQ        = 30;

  // stage counts of the pipelined arithmetic units
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 32;
  localparam int QUO_W       = DIV_STAGES;

  // accept-to-strobe latency
  localparam int PIPE_LAT = 2 * SQRT_STAGES + 2 * DIV_STAGES + 9;

  // divider operand widths
  localparam int NUM_W = 63;
  localparam int DEN_W = 32 + IQ - FRAC_BITS;

  // 1.0 in the internal unit-vector format
  localparam logic [31:0] ONE_IQ = 32'h4000_0000;

  // opposite-vector limit on the cosine: -1.0 plus 0.001
  localparam logic signed [35:0] OPP_LIMIT = -36'sd1072668082;

  // squared axis length below which the x axis is crossed instead
  localparam logic [63:0] AXIS_MIN_L2 = 64'd11529215046068469;

  // identity scalar part as it appears on the 16-bit port
  localparam logic [63:0] QONE_FULL = 64'd1 << FRAC_BITS;
  localparam logic [15:0] QONE16    = QONE_FULL[15:0];

  // case codes
  localparam logic [1:0] CASE_NORMAL = 2'd0;
  localparam logic [1:0] CASE_HALF   = 2'd1;
  localparam logic [1:0] CASE_ZERO   = 2'd2;

endpackage

// File: rtl/core/rtv_isqrt.sv
// ----------------------------------------------------------------------------
// rtv_isqrt
// Pipelined integer square root, floor(sqrt(op)), two operand bits per stage.
// ----------------------------------------------------------------------------
module rtv_isqrt import rtv_pkg::*; (
  input  logic        clk,
  input  logic [63:0] op,
  output logic [31:0] root
);

  logic [63:0] x_r    [SQRT_STAGES];
  logic [34:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
    logic [63:0] x_i;
    logic [34:0] rem_i;
    logic [31:0] root_i;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign x_i    = op;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign x_i    = x_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    // one root digit: bring down two bits, try root*4+1
    always_comb begin
      rem_sh = {rem_i[32:0], x_i[63:62]};
      trial  = {1'b0, root_i, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      x_r[k]    <= {x_i[61:0], 2'b00};
      rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
      root_r[k] <= {root_i[30:0], ge};
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

// File: rtl/core/rtv_div.sv
// ----------------------------------------------------------------------------
// rtv_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rtv_div import rtv_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    localparam int SH = DIV_STAGES - 1 - k;
    logic [NUM_W-1:0] rem_i;
    logic [DEN_W-1:0] den_i;
    logic [QUO_W-1:0] quo_i;
    logic [NUM_W-1:0] hi;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
    end

    // trial subtract of the divisor at this bit weight
    always_comb begin
      hi = rem_i >> SH;
      ge = hi >= NUM_W'(den_i);
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? rem_i - (NUM_W'(den_i) << SH) : rem_i;
      den_r[k] <= den_i;
      quo_r[k] <= {quo_i[QUO_W-2:0], ge};
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// File: rtl/core/rotation_between_vectors_quat.sv
// ----------------------------------------------------------------------------
// rotation_between_vectors_quat
// Unit quaternion (Q1.14) turning a start vector onto a destination vector.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | in_start_x/y/z, in_dest_x/y/z
//  result   | out_valid strobe   | out_quat_w/x/y/z, out_case_code
//
//  One item per cycle; each result passes through two 32-stage square
//  roots, two 32-stage dividers and nine register stages in series.
//  busy stays low: the pipeline never stalls and the receiver cannot stall.
//  Reset (synchronous, active low) clears the valid bits of every stage.
// ----------------------------------------------------------------------------
module rotation_between_vectors_quat import rtv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_start_z,
  input  logic signed [15:0] in_dest_x,
  input  logic signed [15:0] in_dest_y,
  input  logic signed [15:0] in_dest_z,
  output logic               out_valid,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic [1:0]         out_case_code
);

  typedef struct packed {
    logic [2:0][15:0] a;
    logic [2:0][15:0] b;
  } sb_vec_t;

  typedef struct packed {
    logic [5:0] neg;
    logic       zero;
  } sb_unit_t;

  typedef struct packed {
    logic             opp;
    logic [2:0][31:0] ax;
    logic [2:0][63:0] cr;
    logic             zero;
  } sb_root_t;

  typedef struct packed {
    logic [15:0] w;
    logic [2:0]  neg;
    logic        opp;
    logic        zero;
  } sb_quat_t;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: capture and squared lengths
  logic               s1_v_r;
  logic signed [15:0] s1_a_r [3];
  logic signed [15:0] s1_b_r [3];
  logic [31:0]        s1_la_r, s1_lb_r;
  logic [31:0]        la_nxt, lb_nxt;

  always_comb begin
    la_nxt = 32'(in_start_x * in_start_x) + 32'(in_start_y * in_start_y)
           + 32'(in_start_z * in_start_z);
    lb_nxt = 32'(in_dest_x * in_dest_x) + 32'(in_dest_y * in_dest_y)
           + 32'(in_dest_z * in_dest_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    s1_a_r[0] <= in_start_x;
    s1_a_r[1] <= in_start_y;
    s1_a_r[2] <= in_start_z;
    s1_b_r[0] <= in_dest_x;
    s1_b_r[1] <= in_dest_y;
    s1_b_r[2] <= in_dest_z;
    s1_la_r   <= la_nxt;
    s1_lb_r   <= lb_nxt;
  end

  // length roots of both vectors
  logic [31:0] ra, rb;

  rtv_isqrt u_sqrt_a (.clk(clk), .op(64'({s1_la_r, 30'd0})), .root(ra));
  rtv_isqrt u_sqrt_b (.clk(clk), .op(64'({s1_lb_r, 30'd0})), .root(rb));

  logic    qa_v_r  [SQRT_STAGES];
  sb_vec_t qa_sb_r [SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) qa_v_r[k] <= 1'b0;
    end else begin
      qa_v_r[0] <= s1_v_r;
      for (int k = 1; k < SQRT_STAGES; k++) qa_v_r[k] <= qa_v_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      qa_sb_r[0].a[i] <= s1_a_r[i];
      qa_sb_r[0].b[i] <= s1_b_r[i];
    end
    for (int k = 1; k < SQRT_STAGES; k++) qa_sb_r[k] <= qa_sb_r[k-1];
  end

  // stage 2: rounded normalize numerators, |a| * 2^45 + r/2
  logic             s2_v_r;
  logic             s2_zero_r;
  logic [NUM_W-1:0] s2_num_r [6];
  logic [DEN_W-1:0] s2_den_r [6];
  logic [5:0]       s2_neg_r;
  sb_vec_t          qa_out;

  assign qa_out = qa_sb_r[SQRT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= qa_v_r[SQRT_STAGES-1];
    end
    s2_zero_r <= (ra == '0) || (rb == '0);
    for (int i = 0; i < 3; i++) begin
      s2_neg_r[i]     <= qa_out.a[i][15];
      s2_neg_r[i + 3] <= qa_out.b[i][15];
      s2_num_r[i]     <= NUM_W'({(qa_out.a[i][15] ? 16'(-qa_out.a[i]) : qa_out.a[i]), 45'd0})
                       + NUM_W'(ra >> 1);
      s2_num_r[i + 3] <= NUM_W'({(qa_out.b[i][15] ? 16'(-qa_out.b[i]) : qa_out.b[i]), 45'd0})
                       + NUM_W'(rb >> 1);
      s2_den_r[i]     <= DEN_W'(ra);
      s2_den_r[i + 3] <= DEN_W'(rb);
    end
  end

  // six normalize dividers
  logic [QUO_W-1:0] uq [6];

  for (genvar j = 0; j < 6; j++) begin : g_udiv
    rtv_div u_div (.clk(clk), .num(s2_num_r[j]), .den(s2_den_r[j]), .quo(uq[j]));
  end

  logic     du_v_r  [DIV_STAGES];
  sb_unit_t du_sb_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) du_v_r[k] <= 1'b0;
    end else begin
      du_v_r[0] <= s2_v_r;
      for (int k = 1; k < DIV_STAGES; k++) du_v_r[k] <= du_v_r[k-1];
    end
    du_sb_r[0].neg  <= s2_neg_r;
    du_sb_r[0].zero <= s2_zero_r;
    for (int k = 1; k < DIV_STAGES; k++) du_sb_r[k] <= du_sb_r[k-1];
  end

  // stage 3: signed unit vectors
  logic               s3_v_r, s3_zero_r;
  logic signed [31:0] s3_u_r [3];
  logic signed [31:0] s3_w_r [3];
  sb_unit_t           du_out;

  assign du_out = du_sb_r[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= du_v_r[DIV_STAGES-1];
    end
    s3_zero_r <= du_out.zero;
    for (int i = 0; i < 3; i++) begin
      s3_u_r[i] <= du_out.neg[i] ? -$signed(uq[i]) : $signed(uq[i]);
      s3_w_r[i] <= du_out.neg[i + 3] ? -$signed(uq[i + 3]) : $signed(uq[i + 3]);
    end
  end

  // stage 4: all products
  logic               s4_v_r, s4_zero_r;
  logic signed [63:0] s4_dp_r [3];
  logic signed [63:0] s4_cp_r [6];
  logic signed [63:0] s4_sq_r [3];
  logic signed [31:0] s4_u_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_zero_r  <= s3_zero_r;
    for (int i = 0; i < 3; i++) begin
      s4_dp_r[i] <= s3_u_r[i] * s3_w_r[i];
      s4_sq_r[i] <= s3_u_r[i] * s3_u_r[i];
      s4_u_r[i]  <= s3_u_r[i];
    end
    s4_cp_r[0] <= s3_u_r[1] * s3_w_r[2];
    s4_cp_r[1] <= s3_u_r[2] * s3_w_r[1];
    s4_cp_r[2] <= s3_u_r[2] * s3_w_r[0];
    s4_cp_r[3] <= s3_u_r[0] * s3_w_r[2];
    s4_cp_r[4] <= s3_u_r[0] * s3_w_r[1];
    s4_cp_r[5] <= s3_u_r[1] * s3_w_r[0];
  end

  // stage 5: dot, cross and axis lengths
  logic               s5_v_r, s5_zero_r;
  logic signed [63:0] s5_dot_r;
  logic signed [63:0] s5_cr_r [3];
  logic [63:0]        s5_l2a_r, s5_l2b_r;
  logic signed [31:0] s5_u_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
    s5_zero_r  <= s4_zero_r;
    s5_dot_r   <= s4_dp_r[0] + s4_dp_r[1] + s4_dp_r[2];
    s5_cr_r[0] <= s4_cp_r[0] - s4_cp_r[1];
    s5_cr_r[1] <= s4_cp_r[2] - s4_cp_r[3];
    s5_cr_r[2] <= s4_cp_r[4] - s4_cp_r[5];
    s5_l2a_r   <= s4_sq_r[0] + s4_sq_r[1];
    s5_l2b_r   <= s4_sq_r[1] + s4_sq_r[2];
    for (int i = 0; i < 3; i++) s5_u_r[i] <= s4_u_r[i];
  end

  // stage 6: cosine rounded to Q30, axis choice
  logic               s6_v_r, s6_zero_r, s6_alt_r;
  logic signed [35:0] s6_c_r;
  logic signed [63:0] s6_cr_r [3];
  logic [63:0]        s6_l2a_r, s6_l2b_r;
  logic signed [31:0] s6_u_r  [3];
  logic [63:0]        dot_mag;
  logic [63:0]        dot_rnd;

  always_comb begin
    dot_mag = s5_dot_r[63] ? 64'(-s5_dot_r) : 64'(s5_dot_r);
    dot_rnd = (dot_mag + (64'd1 << (IQ - 1))) >> IQ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
    s6_zero_r <= s5_zero_r;
    s6_c_r    <= s5_dot_r[63] ? -$signed(36'(dot_rnd)) : $signed(36'(dot_rnd));
    s6_alt_r  <= s5_l2a_r < AXIS_MIN_L2;
    s6_l2a_r  <= s5_l2a_r;
    s6_l2b_r  <= s5_l2b_r;
    for (int i = 0; i < 3; i++) begin
      s6_cr_r[i] <= s5_cr_r[i];
      s6_u_r[i]  <= s5_u_r[i];
    end
  end

  // stage 7: opposite test and shared root operand
  logic               s7_v_r;
  logic [63:0]        s7_op_r;
  sb_root_t           s7_sb_r;
  logic signed [36:0] t_val;
  logic               opp;

  always_comb begin
    opp   = s6_c_r < OPP_LIMIT;
    t_val = (37'(s6_c_r) + 37'(ONE_IQ)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else begin
      s7_v_r <= s6_v_r;
    end
    if (opp) begin
      s7_op_r <= s6_alt_r ? s6_l2b_r : s6_l2a_r;
    end else begin
      s7_op_r <= {t_val[33:0], 30'd0};
    end
    s7_sb_r.opp  <= opp;
    s7_sb_r.zero <= s6_zero_r;
    if (s6_alt_r) begin
      s7_sb_r.ax[0] <= '0;
      s7_sb_r.ax[1] <= 32'(-s6_u_r[2]);
      s7_sb_r.ax[2] <= s6_u_r[1];
    end else begin
      s7_sb_r.ax[0] <= 32'(-s6_u_r[1]);
      s7_sb_r.ax[1] <= s6_u_r[0];
      s7_sb_r.ax[2] <= '0;
    end
    for (int i = 0; i < 3; i++) s7_sb_r.cr[i] <= s6_cr_r[i];
  end

  // shared root: s for the normal case, axis length for the half turn
  logic [31:0] rt;

  rtv_isqrt u_sqrt_c (.clk(clk), .op(s7_op_r), .root(rt));

  logic     qc_v_r  [SQRT_STAGES];
  sb_root_t qc_sb_r [SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) qc_v_r[k] <= 1'b0;
    end else begin
      qc_v_r[0] <= s7_v_r;
      for (int k = 1; k < SQRT_STAGES; k++) qc_v_r[k] <= qc_v_r[k-1];
    end
    qc_sb_r[0] <= s7_sb_r;
    for (int k = 1; k < SQRT_STAGES; k++) qc_sb_r[k] <= qc_sb_r[k-1];
  end

  // stage 8: quaternion numerators, divisor and scalar part
  logic             s8_v_r;
  logic [NUM_W-1:0] s8_num_r [3];
  logic [DEN_W-1:0] s8_den_r;
  sb_quat_t         s8_sb_r;
  sb_root_t         qc_out;
  logic [31:0]      s_fix;
  logic [DEN_W-1:0] den_nrm;
  logic [32:0]      w_sum;
  logic [31:0]      n_fix;
  logic [31:0]      ax_mag [3];
  logic             ax_neg [3];
  logic [63:0]      cr_mag [3];

  assign qc_out = qc_sb_r[SQRT_STAGES-1];

  always_comb begin
    s_fix   = (rt == '0) ? 32'd1 : rt;
    den_nrm = DEN_W'(s_fix) << (IQ - FRAC_BITS);
    w_sum   = 33'(s_fix) + (33'd1 << (IQ - FRAC_BITS));
    n_fix   = (rt == '0) ? ONE_IQ : rt;
    for (int i = 0; i < 3; i++) begin
      cr_mag[i] = qc_out.cr[i][63] ? 64'(-$signed(qc_out.cr[i])) : qc_out.cr[i];
      if (rt == '0) begin
        ax_mag[i] = (i == 0) ? ONE_IQ : '0;
        ax_neg[i] = 1'b0;
      end else begin
        ax_mag[i] = qc_out.ax[i][31] ? 32'(-$signed(qc_out.ax[i])) : qc_out.ax[i];
        ax_neg[i] = qc_out.ax[i][31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else begin
      s8_v_r <= qc_v_r[SQRT_STAGES-1];
    end
    s8_sb_r.opp  <= qc_out.opp;
    s8_sb_r.zero <= qc_out.zero;
    if (qc_out.opp) begin
      s8_den_r  <= DEN_W'(n_fix);
      s8_sb_r.w <= '0;
      for (int i = 0; i < 3; i++) begin
        s8_num_r[i]   <= (NUM_W'(ax_mag[i]) << FRAC_BITS) + NUM_W'(n_fix >> 1);
        s8_sb_r.neg[i] <= ax_neg[i];
      end
    end else begin
      s8_den_r  <= den_nrm;
      s8_sb_r.w <= 16'(w_sum >> (IQ + 1 - FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
        s8_num_r[i]   <= NUM_W'(cr_mag[i]) + NUM_W'(den_nrm >> 1);
        s8_sb_r.neg[i] <= qc_out.cr[i][63];
      end
    end
  end

  // three quaternion dividers
  logic [QUO_W-1:0] qq [3];

  for (genvar j = 0; j < 3; j++) begin : g_qdiv
    rtv_div u_div (.clk(clk), .num(s8_num_r[j]), .den(s8_den_r), .quo(qq[j]));
  end

  logic     dq_v_r  [DIV_STAGES];
  sb_quat_t dq_sb_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) dq_v_r[k] <= 1'b0;
    end else begin
      dq_v_r[0] <= s8_v_r;
      for (int k = 1; k < DIV_STAGES; k++) dq_v_r[k] <= dq_v_r[k-1];
    end
    dq_sb_r[0] <= s8_sb_r;
    for (int k = 1; k < DIV_STAGES; k++) dq_sb_r[k] <= dq_sb_r[k-1];
  end

  // output register
  sb_quat_t    dq_out;
  logic [15:0] q_lo [3];

  assign dq_out = dq_sb_r[DIV_STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_lo[i] = dq_out.neg[i] ? 16'(-qq[i]) : qq[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dq_v_r[DIV_STAGES-1];
    end
    if (dq_out.zero) begin
      out_quat_w    <= QONE16;
      out_quat_x    <= '0;
      out_quat_y    <= '0;
      out_quat_z    <= '0;
      out_case_code <= CASE_ZERO;
    end else begin
      out_quat_w    <= dq_out.w;
      out_quat_x    <= q_lo[0];
      out_quat_y    <= q_lo[1];
      out_quat_z    <= q_lo[2];
      out_case_code <= dq_out.opp ? CASE_HALF : CASE_NORMAL;
    end
  end

`ifndef SYNTHESIS
  // every result traces back to an accepted item one latency earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching accepted item");

  // zero-length input gives the identity
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_case_code == CASE_ZERO) |->
      (out_quat_w == QONE16 && out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0))
    else $error("zero-length item did not give the identity");

  // a half turn has no scalar part
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_case_code == CASE_HALF) |-> out_quat_w == '0)
    else $error("half turn with nonzero scalar part");
`endif

endmodule

// File: sim/rotation_between_vectors_quat_checker.sv
// ----------------------------------------------------------------------------
// rotation_between_vectors_quat_checker
// Watches the item and result channels of the rotation block, computes the
// expected quaternion for each accepted item and compares results in order.
// ----------------------------------------------------------------------------
module rotation_between_vectors_quat_checker import rtv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_start_z,
  input  logic signed [15:0] in_dest_x,
  input  logic signed [15:0] in_dest_y,
  input  logic signed [15:0] in_dest_z,
  input  logic               out_valid,
  input  logic signed [15:0] out_quat_w,
  input  logic signed [15:0] out_quat_x,
  input  logic signed [15:0] out_quat_y,
  input  logic signed [15:0] out_quat_z,
  input  logic [1:0]         out_case_code,
  output int                 fail_count,
  output int                 pending,
  output int                 n_results,
  output int                 n_half,
  output int                 n_zero
);

  typedef struct packed {
    logic [15:0] w, x, y, z;
    logic [1:0]  code;
  } quat_t;

  quat_t quat_queue[$];

  // integer square root, floor
  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // division rounding half away from zero, den positive
  function automatic longint div_half_away(longint num, longint den);
    logic [63:0] m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // direction of a vector as Q30 unit components
  function automatic void to_unit(input longint a[3], input longint l2,
                                  output longint u[3]);
    longint r;
    r = longint'(sqrt_floor(l2 << IQ));
    for (int i = 0; i < 3; i++) u[i] = div_half_away(a[i] * (64'sd1 << 45), r);
  endfunction

  function automatic quat_t rotation_quat(longint a[3], longint b[3]);
    longint u[3], v[3], ax[3], cr[3], q[4];
    longint la, lb, c, s, n, den;
    quat_t e;
    la = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    lb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
    if (la == 0 || lb == 0) begin
      e.code = CASE_ZERO;
      q[0] = 64'sd1 << FRAC_BITS;
      q[1] = 0; q[2] = 0; q[3] = 0;
    end else begin
      to_unit(a, la, u);
      to_unit(b, lb, v);
      c = div_half_away(u[0] * v[0] + u[1] * v[1] + u[2] * v[2], 64'sd1 << IQ);
      if (c < longint'(OPP_LIMIT)) begin
        // opposite directions: half turn about an axis normal to u
        e.code = CASE_HALF;
        ax[0] = -u[1]; ax[1] = u[0]; ax[2] = 0;
        if (u[0] * u[0] + u[1] * u[1] < longint'(AXIS_MIN_L2)) begin
          ax[0] = 0; ax[1] = -u[2]; ax[2] = u[1];
        end
        n = longint'(sqrt_floor(ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2]));
        if (n == 0) begin
          ax[0] = 64'sd1 << IQ; ax[1] = 0; ax[2] = 0; n = 64'sd1 << IQ;
        end
        q[0] = 0;
        for (int i = 0; i < 3; i++)
          q[i + 1] = div_half_away(ax[i] * (64'sd1 << FRAC_BITS), n);
      end else begin
        e.code = CASE_NORMAL;
        s = longint'(sqrt_floor((2 * ((64'sd1 << IQ) + c)) << IQ));
        if (s == 0) s = 1;
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        q[0] = div_half_away(s, 64'sd1 << (IQ + 1 - FRAC_BITS));
        den = s * (64'sd1 << (IQ - FRAC_BITS));
        for (int i = 0; i < 3; i++) q[i + 1] = div_half_away(cr[i], den);
      end
    end
    e.w = q[0][15:0]; e.x = q[1][15:0]; e.y = q[2][15:0]; e.z = q[3][15:0];
    return e;
  endfunction

  assign pending = quat_queue.size();

  initial begin
    fail_count = 0; n_results = 0; n_half = 0; n_zero = 0;
  end

  // predict on accept, compare on strobe
  always @(posedge clk) begin
    quat_t got, want;
    longint a[3], b[3];
    if (rst_n) begin
      if (start && !busy) begin
        a[0] = in_start_x; a[1] = in_start_y; a[2] = in_start_z;
        b[0] = in_dest_x;  b[1] = in_dest_y;  b[2] = in_dest_z;
        quat_queue.push_back(rotation_quat(a, b));
      end
      if (out_valid) begin
        got = '{out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_case_code};
        n_results++;
        if (out_case_code == CASE_HALF) n_half++;
        if (out_case_code == CASE_ZERO) n_zero++;
        if (quat_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = quat_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch w/x/y/z/code exp %h %h %h %h %0d got %h %h %h %h %0d",
                       want.w, want.x, want.y, want.z, want.code,
                       got.w, got.x, got.y, got.z, got.code);
          end
        end
      end
    end
  end

endmodule

// File: sim/rotation_between_vectors_quat_tb.sv
// ----------------------------------------------------------------------------
// rotation_between_vectors_quat_tb
// Drives vector pairs into the rotation block: directed extremes, equal,
// opposite and zero-length vectors, then random pairs with random gaps.
// ----------------------------------------------------------------------------
module rotation_between_vectors_quat_tb import rtv_pkg::*;;

  localparam int MAX_CYCLES = 200000;

  logic clk, rst_n, start, busy, out_valid;
  logic signed [15:0] in_start_x, in_start_y, in_start_z;
  logic signed [15:0] in_dest_x, in_dest_y, in_dest_z;
  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic [1:0] out_case_code;
  int fail_count, pending, n_results, n_half, n_zero, n_items, cycles;

  rotation_between_vectors_quat u_dut (.*);

  rotation_between_vectors_quat_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > MAX_CYCLES) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // present one item and hold until accepted, then maybe idle
  task automatic send_item(logic [15:0] sx, sy, sz, dx, dy, dz);
    int gap;
    start <= 1'b1;
    in_start_x <= sx; in_start_y <= sy; in_start_z <= sz;
    in_dest_x <= dx; in_dest_y <= dy; in_dest_z <= dz;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(0, 40) == 0) gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] sx, sy, sz, k;
    n_items = 0;
    rst_n = 0; start = 0;
    in_start_x = 0; in_start_y = 0; in_start_z = 0;
    in_dest_x = 0; in_dest_y = 0; in_dest_z = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero-length, extremes, equal, opposite, both half-turn axes
    send_item(0, 0, 0, 1, 2, 3);
    send_item(1, 2, 3, 0, 0, 0);
    send_item(0, 0, 0, 0, 0, 0);
    send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'h8000, 0, 0, 16'h7fff, 0, 0);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(1, 0, 0, 0, 1, 0);
    send_item(0, 0, 1, 0, 0, -1);
    send_item(0, 0, 16'h7fff, 0, 0, 16'h8000);
    send_item(5, 0, 0, -5, 0, 0);
    send_item(0, 3, 0, 0, -7, 0);
    send_item(1, 1, 100, -1, -1, -100);
    send_item(1, 2, 3, 1, 2, 3);
    send_item(-1, -1, -1, 16'h7fff, 1, 16'h8000);
    send_item(16'hffff, 16'hffff, 16'hffff, 1, 1, 1);
    send_item(100, 0, 0, -100, 3, 0);
    send_item(0, 1, 0, 0, 0, 1);

    // random: mostly general pairs, some near-opposite, some zero-length
    for (int i = 0; i < 700; i++) begin
      sx = rand_comp(); sy = rand_comp(); sz = rand_comp();
      case ($urandom_range(0, 9))
        0, 1: begin
          k = 16'($urandom_range(1, 3));
          if (sx == 16'h8000 || sy == 16'h8000 || sz == 16'h8000) k = 1;
          send_item(sx, sy, sz, -sx * k, -sy * k, -sz * k);
        end
        2: send_item(sx, sy, sz, sx + 16'($urandom_range(0, 2)), sy, sz);
        3: send_item(0, 0, 0, rand_comp(), rand_comp(), rand_comp());
        default: send_item(sx, sy, sz, rand_comp(), rand_comp(), rand_comp());
      endcase
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);
    $display("items sent %0d, results checked %0d", n_items, n_results);
    $display("half turns %0d, zero-length %0d", n_half, n_zero);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: rotation_between_vectors_quat.f
rtl/core/rtv_pkg.sv
rtl/core/rtv_isqrt.sv
rtl/core/rtv_div.sv
rtl/core/rotation_between_vectors_quat.sv
sim/rotation_between_vectors_quat_checker.sv
sim/rotation_between_vectors_quat_tb.sv
